>>> rtl/rgbe_rle_pkg.sv
package rgbe_rle_pkg;

  localparam int unsigned MAX_LINE_WIDTH_DEF = 32767;

  localparam int unsigned WIDTH_W = 15;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h02;
  localparam logic [BYTE_W-1:0] LIT_MAX     = 8'd128;

  typedef enum logic [6:0] {
    PH_MARK1  = 7'b0000001,
    PH_MARK2  = 7'b0000010,
    PH_WHIGH  = 7'b0000100,
    PH_WLOW   = 7'b0001000,
    PH_COUNT  = 7'b0010000,
    PH_LIT    = 7'b0100000,
    PH_RUNVAL = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                header_error;
    logic                last_in_line;
    logic [POS_W-1:0]    seg_start;
    logic [COUNT_W-1:0]  seg_count;
    logic [BYTE_W-1:0]   seg_value;
  } seg_t;

endpackage

>>> rtl/rgbe_scanline_rle_decoder_core.sv
// Decodes the run-length coded body of an RGBE picture, one byte per item, at one item per
// clock cycle while the output buffer's second entry is free. Each scanline opens with
// 0x02 0x02 and a big-endian 16-bit width; a bad marker or a width other than cfg_wdata
// (saturated at MAX_LINE_WIDTH) gives one item with header_error set on the width low
// byte, and decoding continues with the configured width. Literal bytes give one-byte
// segments; a repeat run gives one segment. Segments are clipped at the end of the line's
// four planes, and anything past it is dropped. The whole phase update sits between the
// input handshake and the result register; a two-entry output buffer lets input flow on
// while a result waits. Change the width only while the block is idle.
module rgbe_scanline_rle_decoder_core #(
  parameter int unsigned MAX_LINE_WIDTH = rgbe_rle_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,    // line_width
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // seg_value[7:0], seg_count[14:8], seg_start[31:15]
  output logic        out_tlast,    // last_in_line
  output logic        out_tuser     // header_error
);

  localparam logic [rgbe_rle_pkg::WIDTH_W-1:0] MaxW = rgbe_rle_pkg::WIDTH_W'(MAX_LINE_WIDTH);

  logic [rgbe_rle_pkg::WIDTH_W-1:0] line_width_r;
  rgbe_rle_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                       literal_left_r, literal_left_nxt;
  logic [6:0]                       run_length_r, run_length_nxt;
  logic [rgbe_rle_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]                       whigh_r, whigh_nxt;
  logic                             marker_bad_r, marker_bad_nxt;

  rgbe_rle_pkg::seg_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic               out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic               res_valid, in_fire, drain;

  logic [rgbe_rle_pkg::WIDTH_W-1:0] cw;
  logic [rgbe_rle_pkg::POS_W-1:0]   total, room, end_pos17;
  logic [rgbe_rle_pkg::POS_W:0]     end_pos;
  logic [6:0]                       em_count_in, em_count;
  logic                             em_ok;
  logic [15:0]                      rx_width;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign drain     = !out_valid_r || out_tready;

  assign cw       = (line_width_r > MaxW) ? MaxW : line_width_r;
  assign total    = {cw, 2'b00};
  assign rx_width = {whigh_r, in_tdata};

  // segment emission: clip at line end
  assign em_count_in = (phase_r == rgbe_rle_pkg::PH_LIT) ? 7'd1 : run_length_r;
  assign em_ok       = pos_r < total;
  assign room        = total - pos_r;
  assign em_count    = ({10'd0, em_count_in} > room) ? room[6:0] : em_count_in;
  assign end_pos     = {1'b0, pos_r} + {11'd0, em_count};
  assign end_pos17   = end_pos[rgbe_rle_pkg::POS_W-1:0];

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    run_length_nxt   = run_length_r;
    pos_nxt          = pos_r;
    whigh_nxt        = whigh_r;
    marker_bad_nxt   = marker_bad_r;
    res              = '0;
    res_valid        = 1'b0;
    if (in_fire) begin
      case (phase_r)
        rgbe_rle_pkg::PH_MARK1: begin
          marker_bad_nxt = (in_tdata != rgbe_rle_pkg::MARKER_BYTE);
          pos_nxt        = '0;
          phase_nxt      = rgbe_rle_pkg::PH_MARK2;
        end
        rgbe_rle_pkg::PH_MARK2: begin
          if (in_tdata != rgbe_rle_pkg::MARKER_BYTE) marker_bad_nxt = 1'b1;
          phase_nxt = rgbe_rle_pkg::PH_WHIGH;
        end
        rgbe_rle_pkg::PH_WHIGH: begin
          whigh_nxt = in_tdata;
          phase_nxt = rgbe_rle_pkg::PH_WLOW;
        end
        rgbe_rle_pkg::PH_WLOW: begin
          if (marker_bad_r || (rx_width != {1'b0, cw})) begin
            res.header_error = 1'b1;
            res_valid        = 1'b1;
          end
          phase_nxt = rgbe_rle_pkg::PH_COUNT;
        end
        rgbe_rle_pkg::PH_COUNT: begin
          if (in_tdata <= rgbe_rle_pkg::LIT_MAX) begin
            literal_left_nxt = in_tdata;
            if (in_tdata == 8'd0) begin
              phase_nxt = (pos_r >= total) ? rgbe_rle_pkg::PH_MARK1 : rgbe_rle_pkg::PH_COUNT;
            end else begin
              phase_nxt = rgbe_rle_pkg::PH_LIT;
            end
          end else begin
            run_length_nxt = in_tdata[6:0];
            phase_nxt      = rgbe_rle_pkg::PH_RUNVAL;
          end
        end
        rgbe_rle_pkg::PH_LIT, rgbe_rle_pkg::PH_RUNVAL: begin
          if (em_ok) begin
            res.seg_value    = in_tdata;
            res.seg_count    = em_count;
            res.seg_start    = pos_r;
            res.last_in_line = (end_pos >= {1'b0, total});
            res_valid        = 1'b1;
            pos_nxt          = end_pos17;
          end
          literal_left_nxt = literal_left_r - 8'd1;
          if ((phase_r == rgbe_rle_pkg::PH_RUNVAL) || (literal_left_nxt == 8'd0)) begin
            phase_nxt = (pos_nxt >= total) ? rgbe_rle_pkg::PH_MARK1 : rgbe_rle_pkg::PH_COUNT;
          end
          if (phase_r == rgbe_rle_pkg::PH_RUNVAL) literal_left_nxt = literal_left_r;
        end
        default: begin
          phase_nxt = rgbe_rle_pkg::PH_MARK1;
        end
      endcase
    end
  end

  // two-entry output buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (drain) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= rgbe_rle_pkg::WIDTH_W'(1);
      phase_r        <= rgbe_rle_pkg::PH_MARK1;
      literal_left_r <= '0;
      run_length_r   <= '0;
      pos_r          <= '0;
      whigh_r        <= '0;
      marker_bad_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) line_width_r <= cfg_wdata;
      phase_r        <= phase_nxt;
      literal_left_r <= literal_left_nxt;
      run_length_r   <= run_length_nxt;
      pos_r          <= pos_nxt;
      whigh_r        <= whigh_nxt;
      marker_bad_r   <= marker_bad_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.seg_start, out_r.seg_count, out_r.seg_value};
  assign out_tlast  = out_r.last_in_line;
  assign out_tuser  = out_r.header_error;

endmodule
